[design/tensor_range_saturation_stats_unit_defines.svh]
// Assertion macros for the tensor range statistics block.
// Expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef TENSOR_RANGE_SATURATION_STATS_UNIT_DEFINES_SVH
`define TENSOR_RANGE_SATURATION_STATS_UNIT_DEFINES_SVH

// condition must hold at every edge outside reset
`define TRSS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define TRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/trss_pkg.sv]
// Shared types and constants of the tensor range statistics block.
// No dependencies.
package trss_pkg;

	typedef enum logic [1:0] {
		DTYPE_INT8  = 2'd0,
		DTYPE_INT32 = 2'd1,
		DTYPE_INT64 = 2'd2,
		DTYPE_UNSUP = 2'd3
	} trss_dtype_t;

	localparam logic signed [63:0] INT8_LO  = -64'sd128;
	localparam logic signed [63:0] INT8_HI  = 64'sd127;
	localparam logic signed [63:0] INT32_LO = 64'shFFFF_FFFF_8000_0000;
	localparam logic signed [63:0] INT32_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] INT64_LO = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] INT64_HI = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [63:0] value;
		logic               is_low;
		logic               is_high;
	} trss_ext_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic empty;
	} trss_ctrl_t;

endpackage

[design/trss_ifs.sv]
// Channel interfaces of the tensor range statistics block.
// Element input, statistics record output and dtype write channel.
interface trss_elem_if;
	logic        valid;
	logic        ready;
	logic [63:0] element_bits;
	logic        last_element;
	logic        empty_tensor;

	modport source (output valid, element_bits, last_element, empty_tensor, input ready);
	modport sink   (input valid, element_bits, last_element, empty_tensor, output ready);
endinterface

interface trss_stats_if;
	logic               valid;
	logic               ready;
	logic [31:0]        element_total;
	logic signed [63:0] min_seen;
	logic signed [63:0] max_seen;
	logic [31:0]        low_rail_count;
	logic [31:0]        high_rail_count;

	modport source (output valid, element_total, min_seen, max_seen, low_rail_count,
		high_rail_count, input ready);
	modport sink   (input valid, element_total, min_seen, max_seen, low_rail_count,
		high_rail_count, output ready);
endinterface

interface trss_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[design/trss_extend.sv]
// Sign extension of raw element bits by type, and rail detection.
// Depends on trss_pkg.
module trss_extend (
	input  logic [63:0]         raw,
	input  logic [1:0]          mode,
	output trss_pkg::trss_ext_t ext
);
	import trss_pkg::*;

	logic signed [63:0] lo;
	logic signed [63:0] hi;

	always_comb begin
		ext.value = {{56{raw[7]}}, raw[7:0]};
		lo        = '0;
		hi        = '0;
		unique case (trss_dtype_t'(mode))
			DTYPE_INT8: begin
				lo = INT8_LO;
				hi = INT8_HI;
			end
			DTYPE_INT32: begin
				ext.value = {{32{raw[31]}}, raw[31:0]};
				lo        = INT32_LO;
				hi        = INT32_HI;
			end
			DTYPE_INT64: begin
				ext.value = raw;
				lo        = INT64_LO;
				hi        = INT64_HI;
			end
			DTYPE_UNSUP: begin
				// read as int8, both limits zero
				lo = '0;
				hi = '0;
			end
			default: begin
				lo = '0;
				hi = '0;
			end
		endcase
		ext.is_low  = (ext.value == lo);
		ext.is_high = (ext.value == hi);
	end

endmodule

[design/trss_accum.sv]
// Running min/max and saturating counters, with the record output register.
// Depends on trss_pkg and trss_stats_if.
module trss_accum #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trss_pkg::trss_ctrl_t ctrl,
	input  trss_pkg::trss_ext_t  ext,
	output logic                 pop,
	trss_stats_if.source         stats
);
	import trss_pkg::*;

	logic signed [63:0]     min_q, max_q, min_nxt, max_nxt;
	logic [COUNT_WIDTH-1:0] seen_q, low_q, high_q, seen_nxt, low_nxt, high_nxt;
	logic                   out_valid_q;
	logic                   emits;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [31:0] clamp32(input logic [COUNT_WIDTH-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	always_comb begin
		min_nxt  = (ext.value < min_q) ? ext.value : min_q;
		max_nxt  = (ext.value > max_q) ? ext.value : max_q;
		seen_nxt = sat_inc(seen_q);
		low_nxt  = ext.is_low ? sat_inc(low_q) : low_q;
		high_nxt = ext.is_high ? sat_inc(high_q) : high_q;
	end

	assign emits       = ctrl.last || ctrl.empty;
	assign pop         = ctrl.valid && (!emits || !out_valid_q || stats.ready);
	assign stats.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= INT64_HI;
			max_q       <= INT64_LO;
			seen_q      <= '0;
			low_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && emits) begin
				min_q       <= INT64_HI;
				max_q       <= INT64_LO;
				seen_q      <= '0;
				low_q       <= '0;
				high_q      <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					min_q  <= min_nxt;
					max_q  <= max_nxt;
					seen_q <= seen_nxt;
					low_q  <= low_nxt;
					high_q <= high_nxt;
				end
				if (stats.ready)
					out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			if (ctrl.empty) begin
				stats.element_total   <= '0;
				stats.min_seen        <= '0;
				stats.max_seen        <= '0;
				stats.low_rail_count  <= '0;
				stats.high_rail_count <= '0;
			end else begin
				stats.element_total   <= clamp32(seen_nxt);
				stats.min_seen        <= min_nxt;
				stats.max_seen        <= max_nxt;
				stats.low_rail_count  <= clamp32(low_nxt);
				stats.high_rail_count <= clamp32(high_nxt);
			end
		end
	end

endmodule

[design/tensor_range_saturation_stats_unit.sv]
// Tensor range statistics unit: input stage, dtype register and assertions.
// Depends on trss_pkg, trss_ifs, trss_extend, trss_accum and the defines header.
//
// Usage:
//   elem  : one tensor element per transfer (raw bits, last and empty flags).
//   stats : one record per tensor, on the last element or an empty-tensor item.
//   cfg   : writes dtype_mode (0 int8, 1 int32, 2 int64, 3 unsupported);
//           always ready; the user must write it only while the unit is idle,
//           since the unit itself does not enforce this.
// Throughput: one element per cycle while no closing element waits on a pending
//   record; compare and counter update are combinational before the accumulators.
// Path: the element that closes a tensor passes the input register, then the
//   output register, where its record is held valid on stats until taken.
// Reset: accumulators restart (min at the largest value, max at the most
//   negative, counts zero), dtype returns to int8, no record is pending.
// Stall: while a record waits on stats, elements that do not close a tensor
//   still flow; a closing element holds in the input register, and elem
//   ready drops once that register cannot drain.
`include "tensor_range_saturation_stats_unit_defines.svh"

module tensor_range_saturation_stats_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	trss_elem_if.sink    elem,
	trss_stats_if.source stats,
	trss_cfg_if.sink     cfg
);
	import trss_pkg::*;

	trss_ctrl_t  ctrl_s1;
	logic [63:0] bits_s1;
	logic [1:0]  dtype_q;
	trss_ext_t   ext;
	logic        pop;

	assign elem.ready = !ctrl_s1.valid || pop;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			dtype_q <= DTYPE_INT8;
		end else begin
			if (cfg.valid)
				dtype_q <= cfg.data;
			if (elem.valid && elem.ready) begin
				ctrl_s1.valid <= 1'b1;
				ctrl_s1.last  <= elem.last_element;
				ctrl_s1.empty <= elem.empty_tensor;
			end else if (pop) begin
				ctrl_s1.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (elem.valid && elem.ready)
			bits_s1 <= elem.element_bits;
	end

	trss_extend u_extend (
		.raw  (bits_s1),
		.mode (dtype_q),
		.ext  (ext)
	);

	trss_accum #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_s1),
		.ext    (ext),
		.pop    (pop),
		.stats  (stats)
	);

	`TRSS_ASSERT_ALWAYS(a_ready_when_empty, ctrl_s1.valid || elem.ready, "input stage empty but not ready")
	`TRSS_ASSERT_NEXT(a_close_emits, pop && (ctrl_s1.last || ctrl_s1.empty), stats.valid, "closing element gave no record")
	`TRSS_ASSERT_NEXT(a_empty_zero, pop && ctrl_s1.empty, stats.element_total == 32'd0 && stats.min_seen == 64'sd0, "empty tensor record not zero")

endmodule
